[hdl/llqd_pkg.sv]
package llqd_pkg;

    localparam int unsigned BIAS_W    = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned REC_W     = 64;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned OUTCOME_W = 3;
    localparam int unsigned QIDX_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned NUM_BIAS  = 4;
    localparam int unsigned QIU_W     = 3;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_ASSIGNED = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_DRAINED  = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_EMPTY    = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_CLEARED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QIU   = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec_enq;
        logic exec_drain;
        logic exec_clear;
        logic load_result;
    } llqd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
    } llqd_status_t;

endpackage

[hdl/llqd_if.sv]
interface llqd_in_if;
    import llqd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [REC_W-1:0]     record;
    modport source (output valid, output operation, output record, input ready);
    modport sink   (input valid, input operation, input record, output ready);
endinterface

interface llqd_out_if;
    import llqd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [QIDX_W-1:0]    queue_index;
    logic [REC_W-1:0]     drained_record;
    modport source (output valid, output outcome, output queue_index,
                    output drained_record, input ready);
    modport sink   (input valid, input outcome, input queue_index,
                    input drained_record, output ready);
endinterface

interface llqd_cfg_if;
    import llqd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/llqd_ctrl.sv]
module llqd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  llqd_pkg::llqd_status_t status,
    output llqd_pkg::llqd_cmd_t    cmd
);
    import llqd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // the output register is free when empty or being taken
    logic out_free;
    assign out_free  = !ovalid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // sequencing: idle -> exec (state update, memory read) -> result
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.op == OP_ENQUEUE || status.op == OP_DRAIN ||
                    status.op == OP_CLEAR)
                begin
                    if (out_free)
                    begin
                        cmd.exec_enq   = (status.op == OP_ENQUEUE);
                        cmd.exec_drain = (status.op == OP_DRAIN);
                        cmd.exec_clear = (status.op == OP_CLEAR);
                        state_next     = S_READ;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.load_result = 1'b1;
                ovalid_next     = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

[hdl/llqd_datapath.sv]
module llqd_datapath #(
    parameter int unsigned NUM_QUEUES  = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  llqd_pkg::llqd_cmd_t              cmd,
    output llqd_pkg::llqd_status_t           status,
    input  logic [llqd_pkg::OP_W-1:0]        in_operation,
    input  logic [llqd_pkg::REC_W-1:0]       in_record,
    input  logic                             cfg_we,
    input  logic [llqd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [llqd_pkg::CFG_DAT_W-1:0]   cfg_data,
    output logic [llqd_pkg::OUTCOME_W-1:0]   outcome,
    output logic [llqd_pkg::QIDX_W-1:0]      queue_index,
    output logic [llqd_pkg::REC_W-1:0]       drained_record
);
    import llqd_pkg::*;

    localparam int unsigned QW   = $clog2(NUM_QUEUES);
    localparam int unsigned PW   = $clog2(QUEUE_DEPTH);
    localparam int unsigned OCCW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned NW   = $clog2(NUM_QUEUES + 1);
    localparam int unsigned LW   = BIAS_W + 1;
    localparam int unsigned AW   = QW + PW;

    logic [OP_W-1:0]  op_reg;
    logic [REC_W-1:0] rec_reg;

    logic [BIAS_W-1:0]  bias_reg [NUM_BIAS];
    logic [QIU_W-1:0]   qiu_reg;

    logic [PW-1:0]      head_reg  [NUM_QUEUES];
    logic [PW-1:0]      tail_reg  [NUM_QUEUES];
    logic [OCCW-1:0]    occ_reg   [NUM_QUEUES];
    logic [COUNT_W-1:0] count_reg [NUM_QUEUES];
    logic [QW-1:0]      dptr_reg;

    logic [REC_W-1:0]   mem [NUM_QUEUES*QUEUE_DEPTH];
    logic [REC_W-1:0]   rdata_reg;

    logic [OUTCOME_W-1:0] pend_outcome_reg;
    logic [QIDX_W-1:0]    pend_qidx_reg;
    logic                 pend_rd_reg;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [QIDX_W-1:0]    qidx_reg;
    logic [REC_W-1:0]     drec_reg;

    assign status.op      = op_reg;
    assign outcome        = outcome_reg;
    assign queue_index    = qidx_reg;
    assign drained_record = drec_reg;

    // effective queue count
    logic [NW-1:0] n_act;
    always_comb
    begin
        if (qiu_reg == '0)
            n_act = NW'(1);
        else if (32'(qiu_reg) > NUM_QUEUES)
            n_act = NW'(NUM_QUEUES);
        else
            n_act = NW'(qiu_reg);
    end

    // least loaded pick over taking-part queues
    logic [QW-1:0] best_q;
    always_comb
    begin
        logic [LW-1:0] best_load;
        logic [LW-1:0] load;
        logic [BIAS_W-1:0] b;
        best_q    = '0;
        best_load = LW'(count_reg[0]) + LW'(bias_reg[0]);
        for (int q = 1; q < NUM_QUEUES; q++)
        begin
            b    = (q < NUM_BIAS) ? bias_reg[q % NUM_BIAS] : '0;
            load = LW'(count_reg[q]) + LW'(b);
            if (q < 32'(n_act) && load < best_load)
            begin
                best_load = load;
                best_q    = QW'(q);
            end
        end
    end

    // round-robin drain pick
    logic [QW-1:0] drain_q;
    logic          drain_hit;
    always_comb
    begin
        logic [QW-1:0] start;
        logic [NW:0]   idx;
        start     = (32'(dptr_reg) < 32'(n_act)) ? dptr_reg : '0;
        drain_q   = '0;
        drain_hit = 1'b0;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            idx = (NW+1)'(start) + (NW+1)'(k);
            if (idx >= (NW+1)'(n_act))
                idx = idx - (NW+1)'(n_act);
            if (!drain_hit && k < 32'(n_act) && occ_reg[idx[QW-1:0]] != '0)
            begin
                drain_hit = 1'b1;
                drain_q   = idx[QW-1:0];
            end
        end
    end

    logic [QW-1:0] dnext;
    always_comb
    begin
        if (32'(drain_q) + 1 >= 32'(n_act))
            dnext = '0;
        else
            dnext = drain_q + QW'(1);
    end

    logic enq_full;
    assign enq_full = (32'(occ_reg[best_q]) >= QUEUE_DEPTH);

    // capture transaction and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= '0;
            qiu_reg <= QIU_W'(NUM_BIAS);
            for (int i = 0; i < NUM_BIAS; i++)
                bias_reg[i] <= '0;
        end
        else
        begin
            if (cmd.capture)
                op_reg <= in_operation;
            if (cfg_we)
            begin
                if (cfg_index <= REG_BIAS3)
                    bias_reg[cfg_index[1:0]] <= cfg_data;
                else if (cfg_index == REG_QIU)
                    qiu_reg <= cfg_data[QIU_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rec_reg <= in_record;
    end

    // queue state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dptr_reg <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                occ_reg[q]   <= '0;
                count_reg[q] <= '0;
            end
        end
        else if (cmd.exec_clear)
        begin
            dptr_reg <= '0;
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                occ_reg[q]   <= '0;
                count_reg[q] <= '0;
            end
        end
        else if (cmd.exec_enq && !enq_full)
        begin
            tail_reg[best_q] <= (32'(tail_reg[best_q]) == QUEUE_DEPTH - 1) ? '0
                                : tail_reg[best_q] + PW'(1);
            occ_reg[best_q]  <= occ_reg[best_q] + OCCW'(1);
            if (count_reg[best_q] != '1)
                count_reg[best_q] <= count_reg[best_q] + COUNT_W'(1);
        end
        else if (cmd.exec_drain && drain_hit)
        begin
            head_reg[drain_q] <= (32'(head_reg[drain_q]) == QUEUE_DEPTH - 1) ? '0
                                 : head_reg[drain_q] + PW'(1);
            occ_reg[drain_q]  <= occ_reg[drain_q] - OCCW'(1);
            dptr_reg          <= dnext;
        end
    end

    // record memory, one write and one registered read
    logic [AW-1:0] waddr, raddr;
    assign waddr = AW'(32'(best_q) * QUEUE_DEPTH + 32'(tail_reg[best_q]));
    assign raddr = AW'(32'(drain_q) * QUEUE_DEPTH + 32'(head_reg[drain_q]));

    always_ff @(posedge clk)
    begin
        if (cmd.exec_enq && !enq_full)
            mem[waddr] <= rec_reg;
        if (cmd.exec_drain)
            rdata_reg <= mem[raddr];
    end

    // pending result, then output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_outcome_reg <= '0;
            pend_qidx_reg    <= '0;
            pend_rd_reg      <= 1'b0;
            outcome_reg      <= '0;
            qidx_reg         <= '0;
            drec_reg         <= '0;
        end
        else
        begin
            if (cmd.exec_enq)
            begin
                pend_outcome_reg <= enq_full ? OUT_REJECTED : OUT_ASSIGNED;
                pend_qidx_reg    <= QIDX_W'(best_q);
                pend_rd_reg      <= 1'b0;
            end
            else if (cmd.exec_drain)
            begin
                pend_outcome_reg <= drain_hit ? OUT_DRAINED : OUT_EMPTY;
                pend_qidx_reg    <= drain_hit ? QIDX_W'(drain_q) : '0;
                pend_rd_reg      <= drain_hit;
            end
            else if (cmd.exec_clear)
            begin
                pend_outcome_reg <= OUT_CLEARED;
                pend_qidx_reg    <= '0;
                pend_rd_reg      <= 1'b0;
            end
            if (cmd.load_result)
            begin
                outcome_reg <= pend_outcome_reg;
                qidx_reg    <= pend_qidx_reg;
                drec_reg    <= pend_rd_reg ? rdata_reg : '0;
            end
        end
    end
endmodule

[hdl/least_loaded_queue_dispatch_unit.sv]
// sequence: capture, then queue update with memory read once the output
//   register is free, then result load; one transaction at a time, and
//   unknown ops go back to idle after capture with no result
// reset: rst_n asynchronous active low clears queue pointers, counts, drain
//   pointer, biases (queues-in-use to NUM_BIAS); record memory is not cleared
module least_loaded_queue_dispatch_unit #(
    parameter int unsigned NUM_QUEUES  = 4,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input logic     clk,
    input logic     rst_n,
    llqd_in_if.sink   in_ch,
    llqd_out_if.source out_ch,
    llqd_cfg_if.sink  cfg
);
    import llqd_pkg::*;

    llqd_cmd_t    cmd;
    llqd_status_t status;

    assign cfg.ready = 1'b1;

    llqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    llqd_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_operation   (in_ch.operation),
        .in_record      (in_ch.record),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .outcome        (out_ch.outcome),
        .queue_index    (out_ch.queue_index),
        .drained_record (out_ch.drained_record)
    );

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !out_ch.valid)
        else $error("result overwrite");

    // no capture while a transaction is in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("overlapping transactions");

    // only drained outcome carries a record
    a_drec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.outcome != OUT_DRAINED) |-> out_ch.drained_record == '0)
        else $error("record on non-drain outcome");
endmodule
